// ===== hw/rtl/npf_pkg.sv =====
// ----------------------------------------------------------------------------
// npf_pkg
// Shared types for the next-prime search block.
// ----------------------------------------------------------------------------
package npf_pkg;

  // Sequencer states of the trial-division search
  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for a request transaction
    ST_TEST,   // compare divisor squared against the candidate
    ST_DIV,    // bit-serial remainder, one candidate bit per cycle
    ST_CHECK,  // act on the remainder
    ST_FOUND   // prime ready, waiting for the output register
  } state_t;

endpackage

// ===== hw/rtl/next_prime_finder.sv =====
// Search: a start_value below 2 goes straight to the result 2. Otherwise each
//   odd candidate is tried against odd divisors in turn, one bit-serial
//   remainder per divisor, until the divisor squared exceeds the candidate.
// Throughput: one transaction in flight; a new request is taken while the
//   previous result still waits in the output register.
// Reset: rst (synchronous, active high) returns to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
// next_prime_finder
// Returns the smallest prime strictly above start_value by trial division
// with odd divisors, using a bit-serial restoring remainder unit.
// ----------------------------------------------------------------------------
module next_prime_finder
  import npf_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [VALUE_BITS-1:0] start_value,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic [VALUE_BITS:0]   prime_found
);

  // Candidate width, divisor width (room for one step past sqrt), square width
  localparam int CW    = VALUE_BITS + 1;
  localparam int DW    = (CW + 1) / 2 + 1;
  localparam int SW    = 2 * DW;
  localparam int CNT_W = $clog2(CW);

  localparam logic [DW-1:0]    FIRST_DIV = DW'(3);
  localparam logic [SW-1:0]    FIRST_SQ  = SW'(9);
  localparam logic [CNT_W-1:0] LAST_BIT  = CNT_W'(CW - 1);

  state_t state, state_next;

  logic [CW-1:0]    cand;
  logic [DW-1:0]    div;
  logic [SW-1:0]    sq;
  logic [CW-1:0]    shreg;
  logic [DW:0]      rem;
  logic [CNT_W-1:0] bit_cnt;

  logic             small_in;
  logic             sq_le;
  logic [DW:0]      rem_shift;
  logic [DW:0]      rem_sub;
  logic             rem_ge;
  logic             load_out;
  logic [CW-1:0]    first_cand;

  // Input decode and first odd candidate
  assign small_in   = (start_value[VALUE_BITS-1:1] == '0);
  assign first_cand = {1'b0, start_value} + (start_value[0] ? CW'(2) : CW'(1));

  // Divisor squared still within candidate
  assign sq_le = (sq <= SW'(cand));

  // One restoring division step
  assign rem_shift = {rem[DW-1:0], shreg[CW-1]};
  assign rem_sub   = rem_shift - {1'b0, div};
  assign rem_ge    = (rem_shift >= {1'b0, div});

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = small_in ? ST_FOUND : ST_TEST;
        end
      end
      ST_TEST: begin
        state_next = sq_le ? ST_DIV : ST_FOUND;
      end
      ST_DIV: begin
        if (bit_cnt == '0) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = ST_TEST;
      end
      ST_FOUND: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    req_ready = (state == ST_IDLE);
    load_out  = (state == ST_FOUND) && (!rsp_valid || rsp_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cand <= small_in ? CW'(2) : first_cand;
          div  <= FIRST_DIV;
          sq   <= FIRST_SQ;
        end
      end
      ST_TEST: begin
        shreg   <= cand;
        rem     <= '0;
        bit_cnt <= LAST_BIT;
      end
      ST_DIV: begin
        rem     <= rem_ge ? rem_sub : rem_shift;
        shreg   <= {shreg[CW-2:0], 1'b0};
        bit_cnt <= bit_cnt - CNT_W'(1);
      end
      ST_CHECK: begin
        if (rem == '0) begin
          // composite: next odd candidate, restart divisors
          cand <= cand + CW'(2);
          div  <= FIRST_DIV;
          sq   <= FIRST_SQ;
        end else begin
          // (d+2)^2 = d^2 + 4d + 4
          div <= div + DW'(2);
          sq  <= sq + SW'({div, 2'b00}) + SW'(4);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      prime_found <= cand;
    end
  end

  // Checks
  a_odd_search: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEST || state == ST_DIV || state == ST_CHECK) |-> (div[0] && cand[0]))
    else $error("even divisor or candidate during search");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_CHECK) |-> (rem < {1'b0, div}))
    else $error("partial remainder not below divisor");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_FOUND))
    else $error("result transaction raised outside found state");

endmodule

// ===== bench/next_prime_finder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_prime_finder_test
// Self-checking bench for the next-prime search block. A short table of
// probes covers the corners of the search (values below two, two itself,
// prime squares and wide gaps, the top of the range). Random values follow,
// mostly small to keep the run short. Each result is compared with a typed-in
// prime or a trial-division predictor; random values run under four idle/stall patterns.
// ----------------------------------------------------------------------------
module next_prime_finder_test;

  localparam int VALUE_BITS   = 16;
  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_ITEMS = 280;
  localparam int NUM_PHASES   = 4;
  localparam int DRAIN_CYCLES = 50;
  localparam int CYCLE_LIMIT  = 10_000_000;
  localparam int REPORT_LIMIT = 10;
  localparam int NUM_PROBES   = 18;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic [VALUE_BITS:0]   prime;
    bit                    known;
  } probe_t;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic [VALUE_BITS:0]   prime;
  } lookup_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  req_valid;
  logic                  req_ready;
  logic [VALUE_BITS-1:0] start_value;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  logic [VALUE_BITS:0]   prime_found;

  lookup_t pending_primes[$];
  int      mismatch_count = 0;
  int      send_idle_pct  = 0;
  int      rsp_stall_pct  = 0;

  // Corner probes; the prime is typed in only where it is obvious
  probe_t probes [NUM_PROBES] = '{
    '{16'd0,     17'd2,     1'b1},  // below two
    '{16'd1,     17'd2,     1'b1},  // below two
    '{16'd2,     17'd3,     1'b1},  // first odd candidate is prime
    '{16'd3,     17'd0,     1'b0},
    '{16'd4,     17'd0,     1'b0},
    '{16'd7,     17'd0,     1'b0},
    '{16'd8,     17'd0,     1'b0},  // 9 is a square of three
    '{16'd48,    17'd0,     1'b0},  // 49 is a square of seven
    '{16'd120,   17'd0,     1'b0},  // 121 square, then more composites
    '{16'd113,   17'd0,     1'b0},  // wide prime gap
    '{16'd32768, 17'd0,     1'b0},
    '{16'd32767, 17'd0,     1'b0},
    '{16'h5555,  17'd0,     1'b0},
    '{16'hAAAA,  17'd0,     1'b0},
    '{16'd65519, 17'd0,     1'b0},
    '{16'd65521, 17'd0,     1'b0},
    '{16'd65534, 17'd0,     1'b0},
    '{16'd65535, 17'd65537, 1'b1}   // needs the extra result bit
  };

  next_prime_finder #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .start_value(start_value),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .prime_found(prime_found)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Smallest prime strictly above v, by odd trial division
  function automatic logic [VALUE_BITS:0] next_prime_above(input logic [VALUE_BITS-1:0] v);
    longint unsigned cand;
    longint unsigned d;
    bit              is_composite;
    if (v < 2) return (VALUE_BITS + 1)'(2);
    cand = 64'(v) + (v[0] ? 64'd2 : 64'd1);
    do begin
      is_composite = 1'b0;
      for (d = 64'd3; d * d <= cand && !is_composite; d += 64'd2)
        if (cand % d == 0) is_composite = 1'b1;
      if (is_composite) cand += 64'd2;
    end while (is_composite);
    return cand[VALUE_BITS:0];
  endfunction

  // Mostly small values; full range and the top end now and then
  function automatic logic [VALUE_BITS-1:0] random_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) return VALUE_BITS'($urandom_range(255));
    else if (pick < 75) return VALUE_BITS'($urandom_range(4095));
    else if (pick < 95) return VALUE_BITS'($urandom_range(65535));
    else return VALUE_BITS'(32'hFFFF - $urandom_range(20));
  endfunction

  // Offer one request transaction and record what it must return
  task automatic send_request(input logic [VALUE_BITS-1:0] v, input logic [VALUE_BITS:0] prime,
                              input bit known);
    lookup_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    start_value <= v;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    entry.value = v;
    entry.prime = known ? prime : next_prime_above(v);
    pending_primes.push_back(entry);
  endtask

  // Hold the request side quiet until every result is back
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_primes.size() != 0) @(posedge clk);
  endtask

  // Response side: check on accept, then pick the next ready level
  always @(posedge clk) begin
    lookup_t entry;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_primes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected transaction: prime_found=%0d", prime_found);
      end else begin
        entry = pending_primes.pop_front();
        if (prime_found !== entry.prime) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: start_value=%0d expected=%0d actual=%0d",
                     entry.value, entry.prime, prime_found);
        end
      end
    end
    rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Stimulus
  initial begin
    int idle_by_phase  [NUM_PHASES] = '{0, 83, 0, 18};
    int stall_by_phase [NUM_PHASES] = '{0, 0, 83, 18};
    rst         <= 1'b1;
    req_valid   <= 1'b0;
    start_value <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners, no idling
    for (int i = 0; i < NUM_PROBES; i++)
      send_request(probes[i].value, probes[i].prime, probes[i].known);
    wait_drained();

    // Random values under each idle/stall pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = idle_by_phase[p];
      rsp_stall_pct = stall_by_phase[p];
      for (int i = 0; i < RANDOM_ITEMS / NUM_PHASES; i++)
        send_request(random_value(), '0, 1'b0);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count += pending_primes.size();
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== next_prime_finder.f =====
hw/rtl/npf_pkg.sv
hw/rtl/next_prime_finder.sv
bench/next_prime_finder_test.sv
